FILE: rtl/flash_memory_command_controller_top_defines.svh
// assertion macros for the flash command controller
// expects clk_i and rst_ni in the scope of every use
`ifndef FLASH_MEMORY_COMMAND_CONTROLLER_TOP_DEFINES_SVH
`define FLASH_MEMORY_COMMAND_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FMC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fmc assertion failed");

// next-cycle implication, checked outside reset
`define FMC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fmc assertion failed");

`endif

FILE: rtl/fmc_pkg.sv
// shared types and codes of the flash command controller
// no dependencies
`default_nettype none

package fmc_pkg;

  // access kinds carried by the command field
  typedef enum logic [1:0] {
    ACC_REG_READ  = 2'd0,
    ACC_REG_WRITE = 2'd1,
    ACC_DMA_OUT   = 2'd2,
    ACC_DMA_IN    = 2'd3
  } access_e;

  // operating modes
  typedef enum logic [2:0] {
    MODE_READ         = 3'd0,
    MODE_CHIP_ERASE   = 3'd1,
    MODE_SECTOR_ERASE = 3'd2,
    MODE_PROGRAM      = 3'd3,
    MODE_STATUS       = 3'd4,
    MODE_SILICON      = 3'd5
  } mode_e;

  // top byte of a command word
  typedef enum logic [7:0] {
    OP_CHIP_ERASE    = 8'h3c,
    OP_SECTOR_ERASE  = 8'h4b,
    OP_ERASE_EXEC    = 8'h78,
    OP_PROGRAM_EXEC  = 8'ha5,
    OP_PROGRAM       = 8'hb4,
    OP_STATUS        = 8'hd2,
    OP_SILICON_ID    = 8'he1,
    OP_READ_ARRAY    = 8'hf0
  } op_e;

  typedef enum logic [1:0] {
    OUT_OK          = 2'd0,
    OUT_UNSUPPORTED = 2'd1,
    OUT_UNKNOWN_CMD = 2'd2,
    OUT_NO_ERASE    = 2'd3
  } outcome_e;

  // array sequencer states
  typedef enum logic [1:0] {
    WK_CLEAR = 2'd0,
    WK_IDLE  = 2'd1,
    WK_FILL  = 2'd2,
    WK_COPY  = 2'd3
  } walk_e;

  // configuration register indexes
  localparam logic [1:0] CFG_TYPE_ID  = 2'd0;
  localparam logic [1:0] CFG_CHIP_ID  = 2'd1;
  localparam logic [1:0] CFG_OLD_ADDR = 2'd2;

  localparam logic [16:0] CMD_REG_ADDR  = 17'h10000;
  localparam logic [7:0]  ST_ERASE_OK   = 8'h08;
  localparam logic [7:0]  ST_ERASE_FAIL = 8'h02;
  localparam logic [7:0]  ST_PROG_OK    = 8'h04;
  localparam logic [7:0]  ST_PROG_FAIL  = 8'h01;
  localparam logic [17:0] SILICON_LEN   = 18'd8;

  // decoded effect of one access
  typedef struct packed {
    outcome_e    outcome;
    logic [31:0] rdata;
    logic [7:0]  dbyte;
    logic        byte_from_array;
    logic        mode_we;
    mode_e       mode;
    logic        status_we;
    logic [7:0]  status;
    logic        epn_we;
    logic [15:0] epn;
    logic        pb_we;
    logic        fill_chip;
    logic        fill_sector;
    logic        copy_start;
    logic [15:0] page;
  } dec_t;

endpackage

`default_nettype wire

FILE: rtl/flash_memory_command_controller_top.sv
// flash command controller: page buffer and byte array memories, mode registers
// depends on fmc_pkg, fmc_decode and the assertion macro header
// every accepted access gives its result on done_o in the next cycle.
// throughput: one access per cycle while busy_o is low; an erase execute then holds busy_o
//   while the sequencer fills the whole array (chip) or one sector, at most the array
//   (sector), a page program execute while it copies the page buffer into the array, all
//   over the single array write port. the receiver cannot stall, results are never held.
// reset: asynchronous, active low; then a clearing pass fills both memories with 0xff
//   while busy_o is high. all sizes must be powers of two; the block does not enforce it.
`default_nettype none
`include "flash_memory_command_controller_top_defines.svh"

module flash_memory_command_controller_top import fmc_pkg::*; #(
  parameter int ARRAY_BYTES  = 131072,
  parameter int PAGE_BYTES   = 128,
  parameter int SECTOR_PAGES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [16:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] write_mask_i,
  input  logic [17:0] transfer_length_i,
  input  logic [16:0] byte_index_i,
  input  logic [7:0]  host_byte_i,
  // result channel
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic [7:0]  device_byte_o,
  output logic [1:0]  outcome_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int AW           = $clog2(ARRAY_BYTES);
  localparam int PW           = $clog2(PAGE_BYTES);
  localparam int CW           = AW + 1;
  localparam int RW           = (AW > 18) ? AW : 18;
  localparam int SECTOR_BYTES = SECTOR_PAGES * PAGE_BYTES;
  // a sector larger than the array wraps onto itself, so the whole array is enough
  localparam int SECTOR_FILL  = (SECTOR_BYTES < ARRAY_BYTES) ? SECTOR_BYTES : ARRAY_BYTES;

  // configuration registers
  logic [31:0] type_id_q;
  logic [31:0] chip_id_q;
  logic        old_addr_q;

  // device registers
  mode_e       mode_q;
  logic [7:0]  status_q;
  logic [15:0] epn_q;

  // array sequencer
  walk_e       state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_q, len_d;
  logic [AW-1:0] base_q, base_d;

  // memories
  logic [7:0]    arr_mem [ARRAY_BYTES];
  logic [7:0]    pb_mem  [PAGE_BYTES];
  logic [7:0]    arr_rd_q;
  logic [7:0]    pb_rd_q;
  logic          arr_we;
  logic [AW-1:0] arr_waddr;
  logic [7:0]    arr_wdata;
  logic [AW-1:0] arr_raddr;
  logic          pb_we;
  logic [PW-1:0] pb_waddr;
  logic [7:0]    pb_wdata;
  logic [PW-1:0] pb_raddr;

  // result word
  logic        done_q;
  logic [31:0] res_rdata_q;
  logic [7:0]  res_byte_q;
  logic        res_from_arr_q;
  outcome_e    res_outcome_q;

  logic        accept;
  dec_t        dec;
  logic [RW-1:0]    rd_start;
  logic [RW-1:0]    rd_sum;
  logic [15:0]      sector_page;
  logic [AW+15:0]   page_ext;
  logic [AW+15:0]   sector_ext;

  assign busy_o      = (state_q != WK_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  fmc_decode #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_decode (
    .command_i         (access_e'(command_i)),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .write_mask_i      (write_mask_i),
    .transfer_length_i (transfer_length_i),
    .byte_index_i      (byte_index_i),
    .mode_i            (mode_q),
    .status_i          (status_q),
    .epn_i             (epn_q),
    .type_id_i         (type_id_q),
    .chip_id_i         (chip_id_q),
    .dec_o             (dec)
  );

  // configuration writes, taken whenever offered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_id_q  <= '0;
      chip_id_q  <= '0;
      old_addr_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TYPE_ID:  type_id_q  <= cfg_data_i;
        CFG_CHIP_ID:  chip_id_q  <= cfg_data_i;
        CFG_OLD_ADDR: old_addr_q <= cfg_data_i[0];
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  // mode, status and erase page number update on an accepted access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_READ;
      status_q <= '0;
      epn_q    <= '0;
    end else if (accept) begin
      if (dec.mode_we) begin
        mode_q <= dec.mode;
      end
      if (dec.status_we) begin
        status_q <= dec.status;
      end
      if (dec.epn_we) begin
        epn_q <= dec.epn;
      end
    end
  end

  // array read address: start offset, doubled for old parts, plus byte index, wrapped
  assign rd_start  = RW'(address_i[15:0]) << old_addr_q;
  assign rd_sum    = rd_start + RW'(byte_index_i);
  assign arr_raddr = rd_sum[AW-1:0];

  // page and sector start offsets in the array, wrapped
  assign sector_page = dec.page & ~16'(SECTOR_PAGES - 1);
  assign page_ext    = {{AW{1'b0}}, dec.page} << PW;
  assign sector_ext  = {{AW{1'b0}}, sector_page} << PW;

  // sequencer: clearing pass, erase fill and page copy share the array write port
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    base_d    = base_q;
    arr_we    = 1'b0;
    arr_waddr = base_q + cnt_q[AW-1:0];
    arr_wdata = 8'hff;
    pb_raddr  = cnt_q[PW-1:0];
    unique case (state_q)
      WK_CLEAR: begin
        arr_we    = 1'b1;
        arr_waddr = cnt_q[AW-1:0];
        if (cnt_q == CW'(ARRAY_BYTES - 1)) begin
          state_d = WK_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      WK_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          if (dec.fill_chip) begin
            state_d = WK_FILL;
            base_d  = '0;
            len_d   = CW'(ARRAY_BYTES);
          end else if (dec.fill_sector) begin
            state_d = WK_FILL;
            base_d  = sector_ext[AW-1:0];
            len_d   = CW'(SECTOR_FILL);
          end else if (dec.copy_start) begin
            state_d = WK_COPY;
            base_d  = page_ext[AW-1:0];
          end
        end
      end
      WK_FILL: begin
        arr_we = 1'b1;
        if (cnt_q == len_q - CW'(1)) begin
          state_d = WK_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      WK_COPY: begin
        // page buffer read runs one step ahead of the array write
        arr_we    = (cnt_q != '0);
        arr_waddr = base_q + cnt_q[AW-1:0] - AW'(1);
        arr_wdata = pb_rd_q;
        if (cnt_q == CW'(PAGE_BYTES)) begin
          state_d = WK_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = WK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WK_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    base_q <= base_d;
  end

  // page buffer port: cleared in the clearing pass, else written by a dma in
  assign pb_we    = (state_q == WK_CLEAR) || (accept && dec.pb_we);
  assign pb_waddr = (state_q == WK_CLEAR) ? cnt_q[PW-1:0] : byte_index_i[PW-1:0];
  assign pb_wdata = (state_q == WK_CLEAR) ? 8'hff : host_byte_i;

  always_ff @(posedge clk_i) begin
    if (pb_we) begin
      pb_mem[pb_waddr] <= pb_wdata;
    end
    pb_rd_q <= pb_mem[pb_raddr];
  end

  // flash array: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (arr_we) begin
      arr_mem[arr_waddr] <= arr_wdata;
    end
    arr_rd_q <= arr_mem[arr_raddr];
  end

  // result word, shown for one cycle after the access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_rdata_q    <= dec.rdata;
      res_byte_q     <= dec.dbyte;
      res_from_arr_q <= dec.byte_from_array;
      res_outcome_q  <= dec.outcome;
    end
  end

  assign done_o        = done_q;
  assign read_data_o   = res_rdata_q;
  assign device_byte_o = res_from_arr_q ? arr_rd_q : res_byte_q;
  assign outcome_o     = res_outcome_q;

  // every accepted access yields exactly one result in the next cycle
  `FMC_ASSERT_NEXT(a_result_follows, accept, done_o)
  `FMC_ASSERT_NEXT(a_no_spurious_result, !accept, !done_o)
  // the array is only written by the sequencer walks
  `FMC_ASSERT_NOW(a_array_write_busy, arr_we, busy_o)
  // a program execute starts the page copy from its first byte
  `FMC_ASSERT_NEXT(a_copy_starts, accept && dec.copy_start, state_q == WK_COPY && cnt_q == '0)

endmodule

`default_nettype wire

FILE: rtl/fmc_decode.sv
// access decoder: turns one access and the current registers into its effect
// depends on fmc_pkg
`default_nettype none

module fmc_decode import fmc_pkg::*; #(
  parameter int PAGE_BYTES = 128
) (
  input  access_e     command_i,
  input  logic [16:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] write_mask_i,
  input  logic [17:0] transfer_length_i,
  input  logic [16:0] byte_index_i,
  input  mode_e       mode_i,
  input  logic [7:0]  status_i,
  input  logic [15:0] epn_i,
  input  logic [31:0] type_id_i,
  input  logic [31:0] chip_id_i,
  output dec_t        dec_o
);

  logic [31:0] cmd;
  logic [31:0] id_word;
  logic        in_range;

  assign cmd      = write_data_i & write_mask_i;
  assign in_range = {1'b0, byte_index_i} < transfer_length_i;
  assign id_word  = (byte_index_i < 17'd4) ? type_id_i : chip_id_i;

  always_comb begin
    dec_o             = '0;
    dec_o.outcome     = OUT_UNSUPPORTED;
    dec_o.mode        = mode_i;
    dec_o.status      = status_i;
    dec_o.epn         = epn_i;
    dec_o.page        = epn_i;
    unique case (command_i)
      ACC_REG_READ: begin
        if (address_i == '0 && mode_i == MODE_STATUS) begin
          dec_o.rdata   = {24'd0, status_i};
          dec_o.outcome = OUT_OK;
        end else if (address_i == '0 && mode_i == MODE_READ) begin
          dec_o.outcome = OUT_OK;
        end
      end
      ACC_REG_WRITE: begin
        if (address_i == '0 && mode_i == MODE_STATUS) begin
          dec_o.status_we = 1'b1;
          dec_o.status    = cmd[7:0];
          dec_o.outcome   = OUT_OK;
        end else if (address_i == CMD_REG_ADDR) begin
          dec_o.outcome = OUT_OK;
          unique case (op_e'(cmd[31:24]))
            OP_CHIP_ERASE: begin
              dec_o.mode_we = 1'b1;
              dec_o.mode    = MODE_CHIP_ERASE;
            end
            OP_SECTOR_ERASE: begin
              dec_o.mode_we = 1'b1;
              dec_o.mode    = MODE_SECTOR_ERASE;
              dec_o.epn_we  = 1'b1;
              dec_o.epn     = cmd[15:0];
            end
            OP_ERASE_EXEC: begin
              if (mode_i == MODE_SECTOR_ERASE) begin
                dec_o.fill_sector = 1'b1;
              end else if (mode_i == MODE_CHIP_ERASE) begin
                dec_o.fill_chip = 1'b1;
              end else begin
                dec_o.outcome = OUT_NO_ERASE;
              end
              dec_o.status_we = 1'b1;
              dec_o.status    = (status_i & ~ST_ERASE_FAIL) | ST_ERASE_OK;
              dec_o.mode_we   = 1'b1;
              dec_o.mode      = MODE_STATUS;
            end
            OP_PROGRAM_EXEC: begin
              dec_o.copy_start = 1'b1;
              dec_o.page       = cmd[15:0];
              dec_o.status_we  = 1'b1;
              dec_o.status     = (status_i & ~ST_PROG_FAIL) | ST_PROG_OK;
              dec_o.mode_we    = 1'b1;
              dec_o.mode       = MODE_STATUS;
            end
            OP_PROGRAM: begin
              dec_o.mode_we = 1'b1;
              dec_o.mode    = MODE_PROGRAM;
            end
            OP_STATUS: begin
              dec_o.mode_we = 1'b1;
              dec_o.mode    = MODE_STATUS;
            end
            OP_SILICON_ID: begin
              dec_o.mode_we = 1'b1;
              dec_o.mode    = MODE_SILICON;
            end
            OP_READ_ARRAY: begin
              dec_o.mode_we = 1'b1;
              dec_o.mode    = MODE_READ;
            end
            default: begin
              dec_o.outcome = OUT_UNKNOWN_CMD;
            end
          endcase
        end
      end
      ACC_DMA_OUT: begin
        if (in_range) begin
          if (address_i == '0 && transfer_length_i == SILICON_LEN &&
              mode_i == MODE_SILICON) begin
            // most significant byte first
            case (byte_index_i[1:0])
              2'd0:    dec_o.dbyte = id_word[31:24];
              2'd1:    dec_o.dbyte = id_word[23:16];
              2'd2:    dec_o.dbyte = id_word[15:8];
              default: dec_o.dbyte = id_word[7:0];
            endcase
            dec_o.outcome = OUT_OK;
          end else if (address_i < CMD_REG_ADDR && mode_i == MODE_READ) begin
            dec_o.byte_from_array = 1'b1;
            dec_o.outcome         = OUT_OK;
          end
        end
      end
      ACC_DMA_IN: begin
        if (in_range && byte_index_i < 17'(PAGE_BYTES) && address_i == '0 &&
            transfer_length_i == 18'(PAGE_BYTES) && mode_i == MODE_PROGRAM) begin
          dec_o.pb_we   = 1'b1;
          dec_o.outcome = OUT_OK;
        end
      end
      default: begin
        dec_o.outcome = OUT_UNSUPPORTED;
      end
    endcase
  end

endmodule

`default_nettype wire
